[rtl/dqe_pkg.sv]
// DNS query encoder package: shared constants, controller/datapath
// command and status structs, header and trailer byte tables.
// No dependencies.
package dqe_pkg;

  localparam int unsigned MAX_NAME_DEF  = 255;
  localparam int unsigned MAX_LABEL_DEF = 63;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam int unsigned HDR_LEN   = 12;
  localparam int unsigned TRL_LEN   = 5;
  localparam int unsigned QLEN_W    = 9;
  localparam int unsigned QLEN_BIAS = 18;
  localparam int unsigned BIDX_W    = 4;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input word
    logic set_inside;  // first character of a name
    logic hdr_push;    // push header byte
    logic len_push;    // push label length byte
    logic lbl_push;    // push buffered label byte
    logic trl_push;    // push trailer byte
    logic fin;         // word completed now is the last of the query
    logic flush;       // commit partial word
    logic err_word;    // commit error word
    logic store_char;  // buffer character
    logic dot_count;   // count a dot
    logic clr_label;   // label released
    logic rd_clr;      // restart label read pointer
    logic bidx_clr;    // restart header/trailer byte index
    logic set_err;     // swallow rest of name
    logic go_idle;     // back to waiting for a name
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_name;
    logic err;
    logic last;
    logic dot;
    logic fail;
    logic push_ok;
    logic out_free;
    logic acc_empty;
    logic label_empty;
    logic lbl_last;
    logic hdr_last;
    logic trl_last;
  } sts_t;

  function automatic logic [7:0] hdr_byte(input logic [BIDX_W-1:0] idx,
                                          input logic [15:0] id);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = 8'h01;   // flags high: RD
      4'd5:    b = 8'h01;   // QDCOUNT low
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trl_byte(input logic [BIDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd2:    b = 8'h01;   // QTYPE A
      4'd4:    b = 8'h01;   // QCLASS IN
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/dns_query_encoder.sv]
// DNS query encoder top level: stream ports, controller and datapath.
// Depends on dqe_pkg, dqe_ctrl, dqe_datapath.
//
// Takes a dotted host name one character per input word and emits a DNS
// A-record query (header with RD set and one question, length-prefixed
// labels, root byte, QTYPE A, QCLASS IN) as output words of up to four
// bytes, first byte in bits 31..24 of data_word. The query identifier is
// sampled on the first character of a name and sent in network order.
// Steps: a plain character is accepted, then evaluated. The first
// character of a name also pushes the header bytes. A dot releases a
// label of n buffered characters: the length byte, the n label bytes
// (the label buffer being read one entry per cycle while output does
// not stall) and a close of the partial word. The last character adds
// the length byte and bytes of its label, the trailer and the closing
// word; a dot as last character adds the empty label that follows. A
// failing character is accepted, evaluated and answered with an error
// word. Output stalls hold the byte sequencer once the packer is full.
// A too long name or label yields one error word (byte_count 0, tlast
// and tuser set); the rest of that name up to its last character then
// produces nothing. No clearing pass is needed after reset.
module dns_query_encoder #(
  parameter int unsigned MAX_NAME  = dqe_pkg::MAX_NAME_DEF,   // 1..493
  parameter int unsigned MAX_LABEL = dqe_pkg::MAX_LABEL_DEF   // 1..63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words: one name character each
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] name_char, [23:8] query_id
  input  logic        s_axis_tlast,   // last_char
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] data_word, [34:32] byte_count,
                                      // [43:35] query_length, [47:44] zero
  output logic        m_axis_tlast,   // end_of_query
  output logic        m_axis_tuser    // name_error
);

  dqe_pkg::cmd_t cmd;
  dqe_pkg::sts_t sts;

  logic [31:0]                 data_word;
  logic [2:0]                  byte_count;
  logic [dqe_pkg::QLEN_W-1:0]  query_length;

  dqe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dqe_datapath #(
    .MAX_NAME  (MAX_NAME),
    .MAX_LABEL (MAX_LABEL)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .name_char_i    (s_axis_tdata[7:0]),
    .last_char_i    (s_axis_tlast),
    .query_id_i     (s_axis_tdata[23:8]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .data_word_o    (data_word),
    .byte_count_o   (byte_count),
    .end_of_query_o (m_axis_tlast),
    .name_error_o   (m_axis_tuser),
    .query_length_o (query_length)
  );

  assign m_axis_tdata = {4'h0, query_length, byte_count, data_word};

endmodule

[rtl/dqe_ctrl.sv]
// DNS query encoder controller: one-hot sequencer for one character step.
// Depends on dqe_pkg (cmd_t, sts_t).
module dqe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  dqe_pkg::sts_t sts_i,
  output dqe_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HDR   = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_ERR   = 8'b0000_1000,
    S_LEN   = 8'b0001_0000,
    S_LBL   = 8'b0010_0000,
    S_TRL   = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   again_q, again_d;   // dot on last char: release a second, empty label

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    again_d = again_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.bidx_clr = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!sts_i.in_name) begin
            cmd_o.set_inside = 1'b1;
            state_d = S_HDR;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_HDR: begin
        if (sts_i.push_ok) begin
          cmd_o.hdr_push = 1'b1;
          if (sts_i.hdr_last) state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.bidx_clr = 1'b1;
        again_d = 1'b0;
        if (sts_i.err) begin
          cmd_o.go_idle = sts_i.last;
          state_d = S_IDLE;
        end else if (sts_i.fail) begin
          state_d = S_ERR;
        end else if (sts_i.dot) begin
          cmd_o.dot_count = 1'b1;
          again_d = sts_i.last;
          state_d = S_LEN;
        end else begin
          cmd_o.store_char = 1'b1;
          state_d = sts_i.last ? S_LEN : S_IDLE;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.err_word = 1'b1;
          cmd_o.go_idle  = sts_i.last;
          cmd_o.set_err  = !sts_i.last;
          state_d = S_IDLE;
        end
      end
      S_LEN: begin
        cmd_o.rd_clr   = 1'b1;
        cmd_o.bidx_clr = 1'b1;
        if (sts_i.push_ok) begin
          cmd_o.len_push = 1'b1;
          if (sts_i.label_empty) begin
            cmd_o.clr_label = 1'b1;
            if (again_q) begin
              again_d = 1'b0;
              state_d = S_LEN;
            end else begin
              state_d = sts_i.last ? S_TRL : S_FLUSH;
            end
          end else begin
            state_d = S_LBL;
          end
        end
      end
      S_LBL: begin
        cmd_o.bidx_clr = 1'b1;
        if (sts_i.push_ok) begin
          cmd_o.lbl_push = 1'b1;
          if (sts_i.lbl_last) begin
            cmd_o.clr_label = 1'b1;
            if (again_q) begin
              again_d = 1'b0;
              state_d = S_LEN;
            end else begin
              state_d = sts_i.last ? S_TRL : S_FLUSH;
            end
          end
        end
      end
      S_TRL: begin
        if (sts_i.push_ok) begin
          cmd_o.trl_push = 1'b1;
          cmd_o.fin      = sts_i.trl_last;
          if (sts_i.trl_last) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.fin = sts_i.last;
        if (sts_i.acc_empty) begin
          cmd_o.go_idle = sts_i.last;
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush   = 1'b1;
          cmd_o.go_idle = sts_i.last;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      again_q <= 1'b0;
    end else begin
      state_q <= state_d;
      again_q <= again_d;
    end
  end

endmodule

[rtl/dqe_datapath.sv]
// DNS query encoder datapath: name state, label buffer memory, byte
// source mux, 4-byte word packer and output register.
// Depends on dqe_pkg.
module dqe_datapath #(
  parameter int unsigned MAX_NAME  = dqe_pkg::MAX_NAME_DEF,
  parameter int unsigned MAX_LABEL = dqe_pkg::MAX_LABEL_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 name_char_i,
  input  logic                       last_char_i,
  input  logic [15:0]                query_id_i,
  input  dqe_pkg::cmd_t              cmd_i,
  output dqe_pkg::sts_t              sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [31:0]                data_word_o,
  output logic [2:0]                 byte_count_o,
  output logic                       end_of_query_o,
  output logic                       name_error_o,
  output logic [dqe_pkg::QLEN_W-1:0] query_length_o
);

  localparam int unsigned CW = $clog2(MAX_LABEL + 1);
  localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int unsigned NW = $clog2(MAX_NAME + 1);
  localparam int unsigned BW = dqe_pkg::BIDX_W;
  localparam int unsigned QW = dqe_pkg::QLEN_W;

  // captured input word
  logic [7:0]  ch_q;
  logic        last_q;
  logic [15:0] id_q;

  logic          inside_q, err_q;
  logic [CW-1:0] label_cnt_q, label_cnt_d;
  logic [NW-1:0] name_cnt_q, name_cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [BW-1:0] bidx_q, bidx_d;

  logic [7:0]    label_mem [MAX_LABEL];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_addr;

  logic [31:0] acc_q;
  logic [1:0]  acc_cnt_q;

  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic [2:0]    out_cnt_q;
  logic          out_eoq_q, out_err_q;
  logic [QW-1:0] out_qlen_q;

  logic          push, full_push, out_free, load;
  logic [7:0]    push_byte;
  logic [QW:0]   qsum;
  logic [QW-1:0] qlen;
  logic [31:0]   flush_word;
  logic [CW:0]   rd_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q   <= name_char_i;
      last_q <= last_char_i;
      id_q   <= query_id_i;
    end
  end

  // ---- name / label counters ----
  always_comb begin
    label_cnt_d = label_cnt_q;
    name_cnt_d  = name_cnt_q;
    if (cmd_i.store_char) begin
      label_cnt_d = label_cnt_q + 1'b1;
      name_cnt_d  = name_cnt_q + 1'b1;
    end
    if (cmd_i.dot_count) name_cnt_d = name_cnt_q + 1'b1;
    if (cmd_i.clr_label) label_cnt_d = '0;
    if (cmd_i.go_idle) begin
      label_cnt_d = '0;
      name_cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      err_q       <= 1'b0;
      label_cnt_q <= '0;
      name_cnt_q  <= '0;
      rd_idx_q    <= '0;
      bidx_q      <= '0;
    end else begin
      label_cnt_q <= label_cnt_d;
      name_cnt_q  <= name_cnt_d;
      rd_idx_q    <= rd_idx_d;
      bidx_q      <= bidx_d;
      if (cmd_i.set_inside) inside_q <= 1'b1;
      if (cmd_i.set_err)    err_q    <= 1'b1;
      if (cmd_i.go_idle) begin
        inside_q <= 1'b0;
        err_q    <= 1'b0;
      end
    end
  end

  always_comb begin
    bidx_d = bidx_q;
    if (cmd_i.hdr_push || cmd_i.trl_push) bidx_d = bidx_q + 1'b1;
    else if (cmd_i.bidx_clr)              bidx_d = '0;
  end

  // ---- label buffer: rdata_q always tracks entry rd_idx_q ----
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.rd_clr)        rd_idx_d = '0;
    else if (cmd_i.lbl_push) rd_idx_d = rd_idx_q + 1'b1;
  end

  assign rd_addr = (rd_idx_d < CW'(MAX_LABEL)) ? rd_idx_d[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) label_mem[label_cnt_q[AW-1:0]] <= ch_q;
    rdata_q <= label_mem[rd_addr];
  end

  assign rd_next = {1'b0, rd_idx_q} + 1'b1;

  // ---- byte source ----
  assign push = cmd_i.hdr_push | cmd_i.len_push | cmd_i.lbl_push | cmd_i.trl_push;

  always_comb begin
    push_byte = 8'h00;
    if (cmd_i.hdr_push)      push_byte = dqe_pkg::hdr_byte(bidx_q, id_q);
    else if (cmd_i.len_push) push_byte = 8'(label_cnt_q);
    else if (cmd_i.lbl_push) push_byte = rdata_q;
    else if (cmd_i.trl_push) push_byte = dqe_pkg::trl_byte(bidx_q);
  end

  // ---- packer ----
  assign out_free  = !out_valid_q || out_ready_i;
  assign full_push = push && (acc_cnt_q == 2'd3);
  assign load      = full_push || cmd_i.flush || cmd_i.err_word;

  assign qsum = (QW+1)'(name_cnt_q) + (QW+1)'(dqe_pkg::QLEN_BIAS);
  assign qlen = qsum[QW-1:0];

  always_comb begin
    case (acc_cnt_q)
      2'd1:    flush_word = {acc_q[7:0], 24'h0};
      2'd2:    flush_word = {acc_q[15:0], 16'h0};
      2'd3:    flush_word = {acc_q[23:0], 8'h0};
      default: flush_word = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q <= '0;
    end else if (cmd_i.flush || full_push) begin
      acc_cnt_q <= '0;
    end else if (push) begin
      acc_cnt_q <= acc_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) acc_q <= {acc_q[23:0], push_byte};
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_eoq_q  <= cmd_i.fin | cmd_i.err_word;
      out_err_q  <= cmd_i.err_word;
      out_qlen_q <= cmd_i.fin ? qlen : '0;
      if (cmd_i.err_word) begin
        out_data_q <= '0;
        out_cnt_q  <= 3'd0;
      end else if (full_push) begin
        out_data_q <= {acc_q[23:0], push_byte};
        out_cnt_q  <= 3'd4;
      end else begin
        out_data_q <= flush_word;
        out_cnt_q  <= {1'b0, acc_cnt_q};
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_word_o    = out_data_q;
  assign byte_count_o   = out_cnt_q;
  assign end_of_query_o = out_eoq_q;
  assign name_error_o   = out_err_q;
  assign query_length_o = out_qlen_q;

  // ---- status ----
  always_comb begin
    sts_o             = '0;
    sts_o.in_name     = inside_q;
    sts_o.err         = err_q;
    sts_o.last        = last_q;
    sts_o.dot         = (ch_q == dqe_pkg::DOT_CHAR);
    sts_o.fail        = (name_cnt_q >= NW'(MAX_NAME)) ||
                        ((ch_q != dqe_pkg::DOT_CHAR) && (label_cnt_q >= CW'(MAX_LABEL)));
    sts_o.push_ok     = out_free || (acc_cnt_q != 2'd3);
    sts_o.out_free    = out_free;
    sts_o.acc_empty   = (acc_cnt_q == 2'd0);
    sts_o.label_empty = (label_cnt_q == '0);
    sts_o.lbl_last    = (rd_next == {1'b0, label_cnt_q});
    sts_o.hdr_last    = (bidx_q == BW'(dqe_pkg::HDR_LEN - 1));
    sts_o.trl_last    = (bidx_q == BW'(dqe_pkg::TRL_LEN - 1));
  end

endmodule
